>>> rtl/fhcp_pkg.sv
// Shared types, constants and helper functions for the framed hex command parser.
// Used by every module in rtl/; depends on nothing else.
package fhcp_pkg;

  // Frame delimiters.
  localparam logic [7:0] CHAR_START = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_END   = 8'h3E;  // '>'

  // CRC-8/CDMA2000: poly 0x9B, init 0xFF, no reflection, no final xor.
  localparam logic [7:0] CRC_POLY = 8'h9B;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame length field width (a stored length never exceeds 15).
  localparam int unsigned LEN_W = 4;

  // Positions 0..HEX_SPAN-1 cover every set-point digit.
  localparam int unsigned HEX_SPAN = 12;

  // Command words, six characters each, in priority order.
  localparam int unsigned NUM_CMDS   = 5;
  localparam int unsigned WORD_CHARS = 6;
  localparam logic [7:0] CMD_WORDS [NUM_CMDS][WORD_CHARS] = '{
    '{"M", "E", "S", "A", "2", "A"},
    '{"R", "E", "D", "T", "1", "0"},
    '{"P", "T", "S", "T", "E", "8"},
    '{"S", "A", "V", "E", "0", "2"},
    '{"E", "X", "I", "T", "C", "6"}
  };

  typedef enum logic [2:0] {
    ST_CRC_ERR     = 3'd0,
    ST_SET_POINTS  = 3'd1,
    ST_MEASURE_ANG = 3'd2,
    ST_READ_TEMPS  = 3'd3,
    ST_PUMP_TOGGLE = 3'd4,
    ST_SAVE        = 3'd5,
    ST_EXIT_PROG   = 3'd6,
    ST_BAD_CMD     = 3'd7
  } fhcp_status_e;

  // First command word maps onto this status code.
  localparam int unsigned CMD_BASE = 2;

  // One closed frame as handed from the front end to the back end.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       crc_c;
    logic [7:0]       crc_s;
    fhcp_status_e     cmd;
    logic [7:0]       room_temp;
    logic [3:0]       temp_band;
    logic [11:0]      close_angle;
    logic [11:0]      open_angle;
    logic [3:0]       angle_band;
  } fhcp_rec_t;

  // ASCII hex digit to value; anything else reads as zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Fold one byte into the running CRC, MSB first.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] c);
    logic [7:0] x;
    x = crc ^ c;
    for (int b = 0; b < 8; b++) begin
      x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

endpackage

>>> rtl/framed_hex_command_parser.sv
// Framed hex command parser: character-in, frame-result-out.
// Instantiates fhcp_front, fhcp_queue and fhcp_back; depends on fhcp_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_char_i) carries one received
//   character per word. '<' opens or restarts a frame, '>' closes it;
//   characters beyond FRAME_CHARS are dropped, characters outside a frame
//   are ignored.
//   Output channel (out_valid_o / out_stall_i / result fields) carries one
//   word per closing '>' seen inside a frame: CRC-8/CDMA2000 check result,
//   decoded set points or command status, and the kept pump bit.
//   Throughput: one character per cycle while in_stall_o is low. The CRC runs two
//   characters behind the store, one byte per cycle, so the frame is fully
//   checked the moment '>' arrives.
//   The result for an accepted '>' passes through the front end, the
//   two-entry record queue, then the output register.
//   Back-pressure: while the output is stalled the result word holds; the
//   queue absorbs up to two closed frames, and in_stall_o rises only once
//   it is full.
//   Reset: rst_ni (asynchronous, active low) drops any open frame, empties
//   the queue and output register, and switches the pump bit off.
module framed_hex_command_parser #(
  parameter int unsigned FRAME_CHARS = 14,
  parameter int unsigned SHORT_CHARS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  frame_status_o,
  output logic [7:0]  room_temp_target_o,
  output logic [3:0]  temp_band_o,
  output logic [11:0] close_angle_target_o,
  output logic [11:0] open_angle_target_o,
  output logic [3:0]  angle_band_o,
  output logic [7:0]  crc_computed_o,
  output logic [7:0]  crc_sent_o,
  output logic        pump_on_o,
  output logic [3:0]  frame_length_o
);
  import fhcp_pkg::*;

  logic      q_full, q_push, q_valid, q_pop;
  fhcp_rec_t push_rec, pop_rec;

  // Front end: framing, storage and running CRC.
  fhcp_front #(
    .FRAME_CHARS (FRAME_CHARS),
    .SHORT_CHARS (SHORT_CHARS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_char_i  (rx_char_i),
    .in_stall_o (in_stall_o),
    .full_i     (q_full),
    .push_o     (q_push),
    .rec_o      (push_rec)
  );

  // Decouple the two halves so either may stall on its own.
  fhcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_rec_i  (push_rec),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_rec_o   (pop_rec)
  );

  // Back end: verdict, pump bit and output register.
  fhcp_back #(
    .FRAME_CHARS (FRAME_CHARS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .rec_valid_i          (q_valid),
    .rec_i                (pop_rec),
    .pop_o                (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .frame_status_o       (frame_status_o),
    .room_temp_target_o   (room_temp_target_o),
    .temp_band_o          (temp_band_o),
    .close_angle_target_o (close_angle_target_o),
    .open_angle_target_o  (open_angle_target_o),
    .angle_band_o         (angle_band_o),
    .crc_computed_o       (crc_computed_o),
    .crc_sent_o           (crc_sent_o),
    .pump_on_o            (pump_on_o),
    .frame_length_o       (frame_length_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (q_full && q_valid))
    else $error("input stalled while queue has room");
  a_setpts_zero_else: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_status_o != ST_SET_POINTS) |->
      (room_temp_target_o == 8'h00 && temp_band_o == 4'h0 &&
       close_angle_target_o == 12'h000 && open_angle_target_o == 12'h000 &&
       angle_band_o == 4'h0))
    else $error("set-point fields not cleared");
  a_drain_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !out_valid_o) |=> out_valid_o)
    else $error("queued frame not moved to the idle output");
`endif

endmodule

>>> rtl/fhcp_front.sv
// Front end: takes characters, tracks framing, stores the body and runs the CRC.
// Emits one fhcp_rec_t per closing delimiter; depends on fhcp_pkg.
module fhcp_front #(
  parameter int unsigned FRAME_CHARS = 14,
  parameter int unsigned SHORT_CHARS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         rx_char_i,
  output logic               in_stall_o,
  input  logic               full_i,
  output logic               push_o,
  output fhcp_pkg::fhcp_rec_t rec_o
);
  import fhcp_pkg::*;

  localparam int unsigned IW = (FRAME_CHARS > 1) ? $clog2(FRAME_CHARS) : 1;

  logic             in_frame_q, in_frame_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       last1_q, last1_d;
  logic [7:0]       last2_q, last2_d;
  logic [7:0]       store_q [FRAME_CHARS];
  logic             accept, store_en;
  logic [7:0]       chars_ext [HEX_SPAN];
  fhcp_status_e     cmd_status;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign store_en   = accept && in_frame_q && (rx_char_i != CHAR_START) &&
                      (rx_char_i != CHAR_END) && (count_q < LEN_W'(FRAME_CHARS));
  assign push_o     = accept && in_frame_q && (rx_char_i == CHAR_END);

  // Framing and running CRC; the CRC trails the store by two characters.
  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    crc_d      = crc_q;
    last1_d    = last1_q;
    last2_d    = last2_q;
    if (accept) begin
      if (rx_char_i == CHAR_START) begin
        in_frame_d = 1'b1;
        count_d    = '0;
        crc_d      = CRC_INIT;
      end else if (in_frame_q && rx_char_i == CHAR_END) begin
        in_frame_d = 1'b0;
        count_d    = '0;
      end else if (store_en) begin
        if (count_q >= LEN_W'(2)) begin
          crc_d = crc_step(crc_q, last2_q);
        end
        last2_d = last1_q;
        last1_d = rx_char_i;
        count_d = count_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    last1_q <= last1_d;
    last2_q <= last2_d;
    if (store_en) begin
      store_q[count_q[IW-1:0]] <= rx_char_i;
    end
  end

  // Set-point digit positions; past the store they read as zero.
  always_comb begin
    for (int k = 0; k < HEX_SPAN; k++) begin
      chars_ext[k] = 8'h00;
      if (k < FRAME_CHARS) begin
        chars_ext[k] = store_q[IW'(k)];
      end
    end
  end

  // Match the stored text against the command words, first hit wins.
  always_comb begin
    logic       hit, done, found;
    logic [7:0] wc, sc;
    cmd_status = ST_BAD_CMD;
    found      = 1'b0;
    for (int w = 0; w < NUM_CMDS; w++) begin
      hit  = 1'b1;
      done = 1'b0;
      for (int k = 0; k < SHORT_CHARS; k++) begin
        wc = 8'h00;
        if (k < WORD_CHARS) begin
          wc = CMD_WORDS[w][k];
        end
        sc = (LEN_W'(k) < count_q) ? store_q[IW'(k)] : 8'h00;
        if (!done) begin
          if (wc != sc) begin
            hit  = 1'b0;
            done = 1'b1;
          end else if (wc == 8'h00) begin
            done = 1'b1;
          end
        end
      end
      if (hit && !found) begin
        found      = 1'b1;
        cmd_status = fhcp_status_e'(3'(CMD_BASE + w));
      end
    end
  end

  always_comb begin
    rec_o.len         = count_q;
    rec_o.crc_c       = crc_q;
    rec_o.crc_s       = {hex_digit(last2_q), hex_digit(last1_q)};
    rec_o.cmd         = cmd_status;
    rec_o.room_temp   = {hex_digit(chars_ext[2]), hex_digit(chars_ext[3])};
    rec_o.temp_band   = hex_digit(chars_ext[4]);
    rec_o.close_angle = {hex_digit(chars_ext[5]), hex_digit(chars_ext[6]),
                         hex_digit(chars_ext[7])};
    rec_o.open_angle  = {hex_digit(chars_ext[8]), hex_digit(chars_ext[9]),
                         hex_digit(chars_ext[10])};
    rec_o.angle_band  = hex_digit(chars_ext[11]);
  end

endmodule

>>> rtl/fhcp_queue.sv
// Two-entry queue of frame records between the front and back ends.
// Depends on fhcp_pkg for the record type.
module fhcp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fhcp_pkg::fhcp_rec_t push_rec_i,
  output logic                full_o,
  output logic                pop_valid_o,
  input  logic                pop_i,
  output fhcp_pkg::fhcp_rec_t pop_rec_o
);
  import fhcp_pkg::*;

  fhcp_rec_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_pop;

  assign full_o      = fill_q[1];
  assign pop_valid_o = (fill_q != 2'd0);
  assign pop_rec_o   = slot_q[rd_ptr_q];
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_rec_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("queue fill count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> fill_q == $past(fill_q) + 2'd1)
    else $error("fill count missed a push");
`endif

endmodule

>>> rtl/fhcp_back.sv
// Back end: checks the CRC, resolves the frame status, keeps the pump bit
// and holds the result word in the output register. Depends on fhcp_pkg.
module fhcp_back #(
  parameter int unsigned FRAME_CHARS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  fhcp_pkg::fhcp_rec_t rec_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          frame_status_o,
  output logic [7:0]          room_temp_target_o,
  output logic [3:0]          temp_band_o,
  output logic [11:0]         close_angle_target_o,
  output logic [11:0]         open_angle_target_o,
  output logic [3:0]          angle_band_o,
  output logic [7:0]          crc_computed_o,
  output logic [7:0]          crc_sent_o,
  output logic                pump_on_o,
  output logic [3:0]          frame_length_o
);
  import fhcp_pkg::*;

  logic         out_valid_q, out_valid_d;
  logic         pump_q, pump_d;
  logic         take, load, short_frame, crc_ok, set_pts;
  fhcp_status_e status;
  fhcp_rec_t    res_d, res_q;

  // Advance when the output register is free or being drained.
  assign take  = !out_valid_q || !out_stall_i;
  assign load  = take && rec_valid_i;
  assign pop_o = load;

  always_comb begin
    short_frame = rec_i.len < LEN_W'(2);
    crc_ok      = !short_frame && (rec_i.crc_c == rec_i.crc_s);
    if (!crc_ok) begin
      status = ST_CRC_ERR;
    end else if (rec_i.len == LEN_W'(FRAME_CHARS)) begin
      status = ST_SET_POINTS;
    end else begin
      status = rec_i.cmd;
    end
    set_pts = (status == ST_SET_POINTS);

    res_d             = rec_i;
    res_d.cmd         = status;
    res_d.crc_c       = short_frame ? 8'h00 : rec_i.crc_c;
    res_d.crc_s       = short_frame ? 8'h00 : rec_i.crc_s;
    res_d.room_temp   = set_pts ? rec_i.room_temp : 8'h00;
    res_d.temp_band   = set_pts ? rec_i.temp_band : 4'h0;
    res_d.close_angle = set_pts ? rec_i.close_angle : 12'h000;
    res_d.open_angle  = set_pts ? rec_i.open_angle : 12'h000;
    res_d.angle_band  = set_pts ? rec_i.angle_band : 4'h0;

    out_valid_d = take ? rec_valid_i : out_valid_q;
    pump_d      = pump_q ^ (load && status == ST_PUMP_TOGGLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pump_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pump_q      <= pump_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign frame_status_o       = res_q.cmd;
  assign room_temp_target_o   = res_q.room_temp;
  assign temp_band_o          = res_q.temp_band;
  assign close_angle_target_o = res_q.close_angle;
  assign open_angle_target_o  = res_q.open_angle;
  assign angle_band_o         = res_q.angle_band;
  assign crc_computed_o       = res_q.crc_c;
  assign crc_sent_o           = res_q.crc_s;
  assign pump_on_o            = pump_q;
  assign frame_length_o       = res_q.len;

`ifndef NO_ASSERTIONS
  a_pump_only_on_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pump_q != $past(pump_q)) |-> (out_valid_q && res_q.cmd == ST_PUMP_TOGGLE))
    else $error("pump bit changed without a toggle command");
  a_setpts_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.cmd == ST_SET_POINTS) |-> res_q.len == LEN_W'(FRAME_CHARS))
    else $error("set points reported for a frame of wrong length");
  a_short_is_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.len < LEN_W'(2)) |->
      (res_q.cmd == ST_CRC_ERR && res_q.crc_c == 8'h00 && res_q.crc_s == 8'h00))
    else $error("short frame not reported as CRC error");
`endif

endmodule
